// ===== hdl/sbst_pkg.sv =====
// ----------------------------------------------------------------------------
// sbst_pkg: shared types and constants for the segment/box slab test
// Holds the coordinate and parameter formats and the item structs.
// ----------------------------------------------------------------------------
package sbst_pkg;

    localparam int COORD_BITS  = 24;               // signed Q16.8 coordinates
    localparam int T_FRAC_BITS = 16;               // fraction bits of t
    localparam int DIFF_BITS   = COORD_BITS + 1;   // exact coordinate difference
    localparam int QUO_BITS    = T_FRAC_BITS + 2;  // quotient bits below 4.0
    localparam int T_BITS      = T_FRAC_BITS + 3;  // signed t in [-2.0, +2.0]
    localparam int TOUT_BITS   = T_FRAC_BITS + 1;  // unsigned t in [0, 1.0]
    localparam int DIV_LAT     = QUO_BITS + 3;     // divider register count

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [T_BITS-1:0]     t_tval;

    localparam t_tval T_ONE = T_BITS'(1 << T_FRAC_BITS);
    localparam t_tval T_SAT = T_BITS'(2 << T_FRAC_BITS);

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
        t_coord box_lo_x;
        t_coord box_lo_y;
        t_coord box_lo_z;
        t_coord box_hi_x;
        t_coord box_hi_y;
        t_coord box_hi_z;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic [TOUT_BITS-1:0] t_enter;
        logic [TOUT_BITS-1:0] t_exit;
    } t_out_item;

endpackage

// ===== hdl/sbst_div.sv =====
// ----------------------------------------------------------------------------
// sbst_div: pipelined slab crossing divider
// Computes (num << T_FRAC_BITS) / den truncated toward zero, saturated to
// +-2.0, one quotient bit per stage, one item per cycle.
// ----------------------------------------------------------------------------
module sbst_div (
    input  logic           i_clk,
    input  sbst_pkg::t_diff i_num,
    input  sbst_pkg::t_diff i_den,
    output sbst_pkg::t_tval o_quo
);
    import sbst_pkg::*;

    localparam int MAG = DIFF_BITS;
    localparam int RW  = MAG + T_FRAC_BITS;
    localparam int DW  = MAG + QUO_BITS;

    logic [MAG-1:0]      r_an;
    logic [MAG-1:0]      r_ad0;
    logic                r_neg0;

    logic [RW-1:0]       r_rem [QUO_BITS+1];
    logic [MAG-1:0]      r_ad  [QUO_BITS+1];
    logic [QUO_BITS-1:0] r_quo [QUO_BITS+1];
    logic                r_neg [QUO_BITS+1];
    logic                r_ovf [QUO_BITS+1];

    t_tval               r_out;

    // take magnitudes and the result sign
    always_ff @(posedge i_clk) begin
        r_an   <= i_num[MAG-1] ? MAG'(-i_num) : MAG'(i_num);
        r_ad0  <= i_den[MAG-1] ? MAG'(-i_den) : MAG'(i_den);
        r_neg0 <= i_num[MAG-1] ^ i_den[MAG-1];
    end

    // scale the dividend, flag quotients of 4.0 and above, then run one
    // restoring step per stage, most significant quotient bit first
    always_ff @(posedge i_clk) begin
        logic [DW-1:0]       v_sh;
        logic [DW-1:0]       v_rem;
        logic [QUO_BITS-1:0] v_q;
        r_rem[0] <= {r_an, {T_FRAC_BITS{1'b0}}};
        r_ad[0]  <= r_ad0;
        r_quo[0] <= '0;
        r_neg[0] <= r_neg0;
        r_ovf[0] <= {2'b00, r_an} >= {r_ad0, 2'b00};
        for (int k = 0; k < QUO_BITS; k++) begin
            v_sh  = DW'(r_ad[k]) << (QUO_BITS - 1 - k);
            v_rem = DW'(r_rem[k]);
            v_q   = r_quo[k];
            if (v_rem >= v_sh) begin
                v_rem = v_rem - v_sh;
                v_q[QUO_BITS-1-k] = 1'b1;
            end
            r_rem[k+1] <= RW'(v_rem);
            r_quo[k+1] <= v_q;
            r_ad[k+1]  <= r_ad[k];
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    // saturate to 2.0 and apply the sign
    always_ff @(posedge i_clk) begin
        logic [QUO_BITS-1:0] v_mag;
        logic                v_sat;
        v_sat = r_ovf[QUO_BITS] |
                (r_quo[QUO_BITS][QUO_BITS-1] & (|r_quo[QUO_BITS][QUO_BITS-2:0]));
        v_mag = v_sat ? QUO_BITS'(T_SAT) : r_quo[QUO_BITS];
        r_out <= r_neg[QUO_BITS] ? -T_BITS'(v_mag) : T_BITS'(v_mag);
    end

    assign o_quo = r_out;

endmodule

// ===== hdl/segment_box_slab_test_top.sv =====
// ----------------------------------------------------------------------------
// segment_box_slab_test_top: segment versus axis-aligned box slab test
// Pipelined slab test over three axes with six parallel dividers.
// ----------------------------------------------------------------------------
// The block takes one segment/box item in every clock cycle (busy stays
// low) and gives its result on o_result, marked by a one-cycle o_valid
// strobe. The receiver cannot stall, so results leave in order, one per
// cycle at most. The six dividers, which resolve one quotient bit per
// stage, make up most of the pipeline; all three axes and both slab
// planes run side by side.
// A miss returns hit = 0 with both t fields at zero.
module segment_box_slab_test_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  sbst_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_valid,
    output sbst_pkg::t_out_item o_result
);
    import sbst_pkg::*;

    // stage 1: input register
    logic     r_s1_v;
    t_in_item r_s1_item;

    // stage 2: differences and parallel-axis checks
    t_coord   v_s  [3];
    t_coord   v_e  [3];
    t_coord   v_lo [3];
    t_coord   v_hi [3];
    logic     r_s2_v;
    t_diff    r_num_lo [3];
    t_diff    r_num_hi [3];
    t_diff    r_den    [3];
    logic [2:0] r_s2_par;
    logic       r_s2_pm;

    // divider outputs and the control that travels beside them
    t_tval      w_q_lo [3];
    t_tval      w_q_hi [3];
    logic       r_dl_v   [DIV_LAT];
    logic [2:0] r_dl_par [DIV_LAT];
    logic       r_dl_pm  [DIV_LAT];

    // stage E1: ordered crossings
    logic       r_e1_v;
    logic [2:0] r_e1_par;
    logic       r_e1_pm;
    t_tval      r_e1_lo [3];
    t_tval      r_e1_hi [3];

    // stage E2: per-axis entry and exit clamped to the segment
    logic       r_e2_v;
    logic       r_e2_pm;
    t_tval      r_e2_ent [3];
    t_tval      r_e2_ext [3];

    // stage E3: output register
    logic       r_out_v;
    t_out_item  r_result;

    // every cycle takes an item
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_s1_item <= i_item;
        end
    end

    // split the item into per-axis lanes
    always_comb begin
        v_s[0]  = r_s1_item.start_x;
        v_s[1]  = r_s1_item.start_y;
        v_s[2]  = r_s1_item.start_z;
        v_e[0]  = r_s1_item.end_x;
        v_e[1]  = r_s1_item.end_y;
        v_e[2]  = r_s1_item.end_z;
        v_lo[0] = r_s1_item.box_lo_x;
        v_lo[1] = r_s1_item.box_lo_y;
        v_lo[2] = r_s1_item.box_lo_z;
        v_hi[0] = r_s1_item.box_hi_x;
        v_hi[1] = r_s1_item.box_hi_y;
        v_hi[2] = r_s1_item.box_hi_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    // form exact differences; a zero direction marks a parallel axis, which
    // misses when the start point lies outside the slab
    always_ff @(posedge i_clk) begin
        logic v_pm;
        v_pm = 1'b0;
        for (int a = 0; a < 3; a++) begin
            r_num_lo[a] <= t_diff'(v_lo[a]) - t_diff'(v_s[a]);
            r_num_hi[a] <= t_diff'(v_hi[a]) - t_diff'(v_s[a]);
            r_den[a]    <= t_diff'(v_e[a]) - t_diff'(v_s[a]);
            r_s2_par[a] <= v_e[a] == v_s[a];
            if ((v_e[a] == v_s[a]) && ((v_s[a] < v_lo[a]) || (v_s[a] > v_hi[a]))) begin
                v_pm = 1'b1;
            end
        end
        r_s2_pm <= v_pm;
    end

    // six crossings in parallel
    for (genvar a = 0; a < 3; a++) begin : g_axis
        sbst_div u_div_lo (
            .i_clk (i_clk),
            .i_num (r_num_lo[a]),
            .i_den (r_den[a]),
            .o_quo (w_q_lo[a])
        );
        sbst_div u_div_hi (
            .i_clk (i_clk),
            .i_num (r_num_hi[a]),
            .i_den (r_den[a]),
            .o_quo (w_q_hi[a])
        );
    end

    // carry valid and parallel flags alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dl_v[k] <= 1'b0;
            end
        end else begin
            r_dl_v[0] <= r_s2_v;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dl_v[k] <= r_dl_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl_par[0] <= r_s2_par;
        r_dl_pm[0]  <= r_s2_pm;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_dl_par[k] <= r_dl_par[k-1];
            r_dl_pm[k]  <= r_dl_pm[k-1];
        end
    end

    // E1: put each axis's crossings in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else begin
            r_e1_v <= r_dl_v[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1_par <= r_dl_par[DIV_LAT-1];
        r_e1_pm  <= r_dl_pm[DIV_LAT-1];
        for (int a = 0; a < 3; a++) begin
            if (w_q_lo[a] > w_q_hi[a]) begin
                r_e1_lo[a] <= w_q_hi[a];
                r_e1_hi[a] <= w_q_lo[a];
            end else begin
                r_e1_lo[a] <= w_q_lo[a];
                r_e1_hi[a] <= w_q_hi[a];
            end
        end
    end

    // E2: clamp entry at 0.0 and exit at 1.0; a parallel axis leaves them open
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_v <= 1'b0;
        end else begin
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e2_pm <= r_e1_pm;
        for (int a = 0; a < 3; a++) begin
            if (r_e1_par[a] || r_e1_lo[a] < 0) begin
                r_e2_ent[a] <= '0;
            end else begin
                r_e2_ent[a] <= r_e1_lo[a];
            end
            if (r_e1_par[a] || r_e1_hi[a] > T_ONE) begin
                r_e2_ext[a] <= T_ONE;
            end else begin
                r_e2_ext[a] <= r_e1_hi[a];
            end
        end
    end

    // E3: combine the axes and decide the hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_e2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        t_tval v_in;
        t_tval v_out;
        v_in  = r_e2_ent[0];
        v_out = r_e2_ext[0];
        for (int a = 1; a < 3; a++) begin
            if (r_e2_ent[a] > v_in) begin
                v_in = r_e2_ent[a];
            end
            if (r_e2_ext[a] < v_out) begin
                v_out = r_e2_ext[a];
            end
        end
        if (!r_e2_pm && (v_in <= v_out)) begin
            r_result.hit     <= 1'b1;
            r_result.t_enter <= v_in[TOUT_BITS-1:0];
            r_result.t_exit  <= v_out[TOUT_BITS-1:0];
        end else begin
            r_result.hit     <= 1'b0;
            r_result.t_enter <= '0;
            r_result.t_exit  <= '0;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_result;

    // a miss carries zero parameters
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.hit) |-> (o_result.t_enter == '0 && o_result.t_exit == '0))
        else $error("miss with nonzero parameters");

    // a hit is ordered and lies within the segment
    a_hit_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.hit) |->
            (o_result.t_enter <= o_result.t_exit &&
             o_result.t_exit <= TOUT_BITS'(T_ONE)))
        else $error("hit parameters out of order or range");

    // a parallel-axis miss never reports a hit
    a_par_miss : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e2_v && r_e2_pm) |=> (o_valid && !o_result.hit))
        else $error("parallel miss reported as hit");

endmodule
